// ----- rtl/des_pkg.sv -----
package des_pkg;

    localparam int unsigned BlockWidth    = 64;
    localparam int unsigned HalfWidth     = 32;
    localparam int unsigned RoundKeyWidth = 48;
    localparam int unsigned CdWidth       = 56;
    localparam int unsigned RoundCount    = 16;

    typedef logic [BlockWidth-1:0]    t_block;
    typedef logic [HalfWidth-1:0]     t_half;
    typedef logic [RoundKeyWidth-1:0] t_round_key;
    typedef logic [CdWidth-1:0]       t_cd;

    typedef enum logic {
        REQ_ENCRYPT = 1'b0,
        REQ_DECRYPT = 1'b1
    } t_req;

    // Table entries count from 1 at the most significant bit, as in the standard.
    localparam byte unsigned IpTab [64] = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

    localparam byte unsigned FpTab [64] = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

    localparam byte unsigned ETab [48] = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
        28,29,30,31,32,1};

    localparam byte unsigned PTab [32] = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};

    localparam byte unsigned Pc1Tab [56] = '{
        57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
        10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
        63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
        14,6,61,53,45,37,29, 21,13,5,28,20,12,4};

    localparam byte unsigned Pc2Tab [48] = '{
        14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
        41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53,
        46,42,50,36,29,32};

    localparam byte unsigned RotTab [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

    localparam logic [3:0] SboxTab [8][64] = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
          0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
          15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
          3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
          13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
          13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
          1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
          13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
          3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
          14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
          11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
          10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
          4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
          13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
          6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
          1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
          2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

    function automatic t_block initial_perm(input t_block x);
        t_block r;
        for (int i = 0; i < 64; i++) begin
            r[63-i] = x[64-IpTab[i]];
        end
        return r;
    endfunction

    function automatic t_block final_perm(input t_block x);
        t_block r;
        for (int i = 0; i < 64; i++) begin
            r[63-i] = x[64-FpTab[i]];
        end
        return r;
    endfunction

    function automatic t_cd key_pc1(input t_block k);
        t_cd r;
        for (int i = 0; i < 56; i++) begin
            r[55-i] = k[64-Pc1Tab[i]];
        end
        return r;
    endfunction

    function automatic t_round_key key_pc2(input t_cd cd);
        t_round_key r;
        for (int i = 0; i < 48; i++) begin
            r[47-i] = cd[56-Pc2Tab[i]];
        end
        return r;
    endfunction

    // Rotates both 28-bit halves left by one if the amount is 1, else by two.
    function automatic t_cd cd_rotate(input t_cd cd, input int unsigned s);
        logic [27:0] c;
        logic [27:0] d;
        c = cd[55:28];
        d = cd[27:0];
        if (s == 1) begin
            c = {c[26:0], c[27]};
            d = {d[26:0], d[27]};
        end else begin
            c = {c[25:0], c[27:26]};
            d = {d[25:0], d[27:26]};
        end
        return {c, d};
    endfunction

    // The Feistel function: expansion, key mixing, S-boxes and P.
    function automatic t_half feistel(input t_half r, input t_round_key k);
        t_round_key x;
        t_half      s;
        t_half      p;
        logic [5:0] six;
        for (int i = 0; i < 48; i++) begin
            x[47-i] = r[32-ETab[i]];
        end
        x = x ^ k;
        for (int i = 0; i < 8; i++) begin
            six = x[47-6*i -: 6];
            s[31-4*i -: 4] = SboxTab[i][{six[5], six[0], six[4:1]}];
        end
        for (int i = 0; i < 32; i++) begin
            p[31-i] = s[32-PTab[i]];
        end
        return p;
    endfunction

endpackage

// ----- rtl/des_if.sv -----
interface des_req_if;
    logic                  valid;
    logic                  ready;
    des_pkg::t_req         req_type;
    des_pkg::t_block       block_in;
    modport source (output valid, req_type, block_in, input ready);
    modport sink (input valid, req_type, block_in, output ready);
endinterface

interface des_rsp_if;
    logic                  valid;
    logic                  ready;
    des_pkg::t_block       block_out;
    modport source (output valid, block_out, input ready);
    modport sink (input valid, block_out, output ready);
endinterface

// ----- rtl/des_block_cipher_core.sv -----
// DES block cipher core.
// Requests arrive on a valid/ready channel: each beat carries one 64-bit block
// and a selector that asks for encryption or decryption. Results leave on a
// second valid/ready channel, one beat per request, in request order.
// The user must load the 64-bit key through i_key_we/i_key_wdata only while the
// core is idle; the core itself does not enforce this. The sixteen round keys are
// pure rewiring of the key register (PC-1, fixed rotations, PC-2), so a beat
// accepted in the cycle right after a key write already uses the new key.
// Throughput is one block per cycle while the output side does not stall. The
// datapath is an unrolled pipeline with one register stage per Feistel round
// plus an input stage. An accepted block passes the input stage and then each
// round stage in order; the last stage presents it as a valid result.
// One Feistel round (expansion, eight S-box lookups, P) sets the stage depth.
// Reset clears the key and all valid bits; no result is pending afterward.
// When the receiver stalls, the whole pipeline holds; ready on the input side
// follows the output side, so no beat is lost or repeated.
module des_block_cipher_core #(
    parameter int unsigned ROUND_COUNT = des_pkg::RoundCount
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_key_we,
    input  des_pkg::t_block   i_key_wdata,
    des_req_if.sink           req,
    des_rsp_if.source         rsp
);

    localparam int unsigned Stages = ROUND_COUNT + 1;

    // Key register and the round keys derived from it by wiring alone.
    des_pkg::t_block       r_key;
    des_pkg::t_cd          ks_cd     [ROUND_COUNT+1];
    des_pkg::t_round_key   round_key [ROUND_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_key_we) begin
            r_key <= i_key_wdata;
        end
    end

    assign ks_cd[0] = des_pkg::key_pc1(r_key);

    for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_key_sched
        assign ks_cd[g+1]   = des_pkg::cd_rotate(ks_cd[g], des_pkg::RotTab[g]);
        assign round_key[g] = des_pkg::key_pc2(ks_cd[g+1]);
    end

    // Pipeline. Stage 0 holds the permuted block; stage i holds it after i rounds.
    logic            r_vld [Stages];
    des_pkg::t_half  r_l   [Stages];
    des_pkg::t_half  r_r   [Stages];
    logic            r_dec [Stages];
    logic            advance;
    des_pkg::t_block ip_blk;

    // Full stall: everything moves only when the last stage is free.
    assign advance   = rsp.ready || !r_vld[Stages-1];
    assign req.ready = advance;
    assign ip_blk    = des_pkg::initial_perm(req.block_in);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < Stages; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (advance) begin
            r_vld[0] <= req.valid;
            for (int i = 1; i < Stages; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_l[0]   <= ip_blk[63:32];
            r_r[0]   <= ip_blk[31:0];
            r_dec[0] <= (req.req_type == des_pkg::REQ_DECRYPT);
            for (int i = 1; i < Stages; i++) begin
                r_l[i]   <= r_r[i-1];
                r_r[i]   <= r_l[i-1] ^ des_pkg::feistel(r_r[i-1],
                    r_dec[i-1] ? round_key[ROUND_COUNT-i] : round_key[i-1]);
                r_dec[i] <= r_dec[i-1];
            end
        end
    end

    // Halves are swapped before the final permutation.
    assign rsp.valid     = r_vld[Stages-1];
    assign rsp.block_out = des_pkg::final_perm({r_r[Stages-1], r_l[Stages-1]});

    // A new result can only appear when the pipeline advanced.
    a_out_from_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(rsp.valid) |-> $past(advance))
        else $error("result appeared without pipeline advance");
    // While stalled the output stays put.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.block_out))
        else $error("stalled result changed");
    // While the output is stalled, the input side is not ready.
    a_ready_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.valid && !rsp.ready |-> !req.ready)
        else $error("input taken while output stalled");

endmodule

// ----- sim/tb_top.sv -----
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // Clock, reset and the key write port of the core.
    logic            i_clk;
    logic            i_rst_n;
    logic            i_key_we;
    des_pkg::t_block i_key_wdata;

    des_req_if req_bus ();
    des_rsp_if rsp_bus ();

    des_block_cipher_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key_we    (i_key_we),
        .i_key_wdata (i_key_wdata),
        .req         (req_bus),
        .rsp         (rsp_bus)
    );

    // The key the core should be using right now, kept next to the blocks
    // still in flight so that every result is predicted under its own key.
    des_pkg::t_block active_key;
    des_pkg::t_block pending_blocks[$];
    int              error_count;
    // When set, neither side of the core idles or stalls.
    bit              steady_flow;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // A generous fixed limit: the whole run needs well under a millisecond.
    initial begin
        #20ms;
        $display("tb_top: errors");
        $finish;
    end

    // Permutation helpers. Table entries count from 1 at the most significant
    // bit of a word of the given width, so entry t selects bit (width - t).
    function automatic des_pkg::t_cd choose_pc1(input des_pkg::t_block k);
        des_pkg::t_cd r;
        for (int i = 0; i < 56; i++) begin
            r[55-i] = k[64-des_pkg::Pc1Tab[i]];
        end
        return r;
    endfunction

    function automatic des_pkg::t_round_key choose_pc2(input des_pkg::t_cd cd);
        des_pkg::t_round_key r;
        for (int i = 0; i < 48; i++) begin
            r[47-i] = cd[56-des_pkg::Pc2Tab[i]];
        end
        return r;
    endfunction

    // One round of the cipher: expand the right half to 48 bits, mix in the
    // round key, substitute through the eight S-boxes and permute with P.
    function automatic des_pkg::t_half round_mix(input des_pkg::t_half r,
                                                 input des_pkg::t_round_key k);
        des_pkg::t_round_key grown;
        des_pkg::t_half      subst;
        des_pkg::t_half      mixed;
        logic [5:0]          chunk;
        logic [1:0]          row;
        logic [3:0]          col;
        for (int i = 0; i < 48; i++) begin
            grown[47-i] = r[32-des_pkg::ETab[i]];
        end
        grown ^= k;
        for (int i = 0; i < 8; i++) begin
            chunk = grown[47-6*i -: 6];
            // The outer bits pick the row and the inner four the column.
            row = {chunk[5], chunk[0]};
            col = chunk[4:1];
            subst[31-4*i -: 4] = des_pkg::SboxTab[i][row*16 + col];
        end
        for (int i = 0; i < 32; i++) begin
            mixed[31-i] = subst[32-des_pkg::PTab[i]];
        end
        return mixed;
    endfunction

    // Full DES of one block: key schedule, IP, sixteen rounds, the swap of
    // the halves and the inverse permutation. Decryption walks the round keys
    // from last to first.
    function automatic des_pkg::t_block des_transform(input des_pkg::t_block key,
                                                      input des_pkg::t_req kind,
                                                      input des_pkg::t_block blk);
        des_pkg::t_round_key sched [16];
        des_pkg::t_cd        cd;
        logic [27:0]         c;
        logic [27:0]         d;
        des_pkg::t_block     perm;
        des_pkg::t_block     joined;
        des_pkg::t_half      left;
        des_pkg::t_half      right;
        des_pkg::t_half      tmp;
        int                  idx;
        cd = choose_pc1(key);
        c = cd[55:28];
        d = cd[27:0];
        for (int n = 0; n < 16; n++) begin
            for (int s = 0; s < des_pkg::RotTab[n]; s++) begin
                c = {c[26:0], c[27]};
                d = {d[26:0], d[27]};
            end
            sched[n] = choose_pc2({c, d});
        end
        for (int i = 0; i < 64; i++) begin
            perm[63-i] = blk[64-des_pkg::IpTab[i]];
        end
        left = perm[63:32];
        right = perm[31:0];
        for (int n = 0; n < 16; n++) begin
            idx = (kind == des_pkg::REQ_DECRYPT) ? 15 - n : n;
            tmp = left ^ round_mix(right, sched[idx]);
            left = right;
            right = tmp;
        end
        joined = {right, left};
        for (int i = 0; i < 64; i++) begin
            perm[63-i] = joined[64-des_pkg::FpTab[i]];
        end
        return perm;
    endfunction

    // Whether a side should idle this cycle: with probability 9/100 unless steady_flow is set.
    function automatic bit take_gap();
        return !steady_flow && ($urandom_range(0, 99) < 9);
    endfunction

    // Sends one beat and records its expected result once it is accepted.
    // Valid stays high between back-to-back beats.
    task automatic send_block(input des_pkg::t_req kind, input des_pkg::t_block blk);
        while (take_gap()) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.req_type <= kind;
        req_bus.block_in <= blk;
        do begin
            @(posedge i_clk);
        end while (!req_bus.ready);
        pending_blocks.push_back(des_transform(active_key, kind, blk));
    endtask

    // Lets the pipeline run dry before the key changes.
    task automatic drain_core();
        req_bus.valid <= 1'b0;
        while (pending_blocks.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
    endtask

    // Writes the key while the core is idle; the next beat may follow in the
    // very next cycle and must already see the new key.
    task automatic load_key(input des_pkg::t_block key);
        drain_core();
        i_key_we    <= 1'b1;
        i_key_wdata <= key;
        @(posedge i_clk);
        i_key_we <= 1'b0;
        active_key = key;
    endtask

    // Output side: random stalls, and every result compared with the oldest
    // expectation.
    always @(posedge i_clk) begin
        des_pkg::t_block want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_blocks.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, rsp_bus.block_out);
                error_count++;
            end else begin
                want = pending_blocks.pop_front();
                if (rsp_bus.block_out !== want) begin
                    $display("%0t: block_out mismatch, expected %h, actual %h",
                             $time, want, rsp_bus.block_out);
                    error_count++;
                end
            end
        end
        rsp_bus.ready <= !take_gap();
    end

    // Zero key straight after reset, with the extreme blocks both ways.
    task automatic test_reset_key();
        send_block(des_pkg::REQ_ENCRYPT, 64'h0);
        send_block(des_pkg::REQ_ENCRYPT, '1);
        send_block(des_pkg::REQ_DECRYPT, 64'h0);
        send_block(des_pkg::REQ_DECRYPT, '1);
    endtask

    // The textbook example key, block and ciphertext, plus walking single bits spaced
    // nine apart with alternating operations, and two alternating bit patterns.
    task automatic test_known_vectors();
        load_key(64'h1334_5779_9BBC_DFF1);
        send_block(des_pkg::REQ_ENCRYPT, 64'h0123_4567_89AB_CDEF);
        send_block(des_pkg::REQ_DECRYPT, 64'h85E8_1354_0F0A_B405);
        for (int i = 0; i < 8; i++) begin
            send_block(des_pkg::t_req'(i[0]), 64'h1 << (i * 9));
        end
        send_block(des_pkg::REQ_ENCRYPT, 64'hAAAA_AAAA_AAAA_AAAA);
        send_block(des_pkg::REQ_DECRYPT, 64'h5555_5555_5555_5555);
    endtask

    // Extreme keys, including one that differs from zero only in the parity
    // bits, which the schedule must ignore.
    task automatic test_key_extremes();
        des_pkg::t_block keys [4];
        keys[0] = '1;
        keys[1] = 64'h0101_0101_0101_0101;
        keys[2] = 64'hFEFE_FEFE_FEFE_FEFE;
        keys[3] = 64'h0;
        foreach (keys[k]) begin
            load_key(keys[k]);
            send_block(des_pkg::REQ_DECRYPT, '1);
            send_block(des_pkg::REQ_ENCRYPT, 64'h0);
        end
    endtask

    // Random traffic under several random keys. Most beats are round trips:
    // a block is encrypted and its ciphertext decrypted right after; the rest
    // are loose random blocks of either kind. One phase runs with no idling.
    task automatic test_random_traffic();
        des_pkg::t_block blk;
        des_pkg::t_block ct;
        for (int phase = 0; phase < 8; phase++) begin
            load_key({$urandom(), $urandom()});
            steady_flow = (phase == 4);
            for (int n = 0; n < 100; n++) begin
                blk = {$urandom(), $urandom()};
                if ($urandom_range(0, 3) != 0) begin
                    ct = des_transform(active_key, des_pkg::REQ_ENCRYPT, blk);
                    send_block(des_pkg::REQ_ENCRYPT, blk);
                    send_block(des_pkg::REQ_DECRYPT, ct);
                end else begin
                    send_block(des_pkg::t_req'($urandom_range(0, 1)), blk);
                    send_block(des_pkg::t_req'($urandom_range(0, 1)),
                               {$urandom(), $urandom()});
                end
            end
            steady_flow = 1'b0;
        end
    endtask

    initial begin
        error_count      = 0;
        steady_flow      = 1'b0;
        active_key       = '0;
        i_rst_n          = 1'b0;
        i_key_we         = 1'b0;
        i_key_wdata      = '0;
        req_bus.valid    = 1'b0;
        req_bus.req_type = des_pkg::REQ_ENCRYPT;
        req_bus.block_in = '0;
        rsp_bus.ready    = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_key();
        test_known_vectors();
        test_key_extremes();
        test_random_traffic();

        // Everything sent; wait for the last results to come out.
        drain_core();
        if (error_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
